@@ sv/deblock_edge_filter_defines.svh @@
// ----------------------------------------------------------------------------
// deblock_edge_filter_defines.svh
// Assertion macros used by the deblocking edge filter top level.
// ----------------------------------------------------------------------------
`ifndef DEBLOCK_EDGE_FILTER_DEFINES_SVH
`define DEBLOCK_EDGE_FILTER_DEFINES_SVH

`ifndef SYNTH
// check on every rising clock edge outside of reset
`define DBF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("deblock_edge_filter: assertion failed");
// check on every rising clock edge, reset included
`define DBF_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("deblock_edge_filter: assertion failed");
`else
`define DBF_ASSERT(label, prop)
`define DBF_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ sv/dbf_pkg.sv @@
// ----------------------------------------------------------------------------
// dbf_pkg
// Types, codes and helpers shared by the deblocking edge filter stages.
// ----------------------------------------------------------------------------
package dbf_pkg;

   // word widths on the stream ports
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 136;

   // width of the half-window sums of the smoothing filters
   localparam int SUM16_W = 11;
   localparam int SUM8_W  = 10;

   // register indexes on the configuration port
   localparam logic CSR_EDGE_LIMIT  = 1'b0;
   localparam logic CSR_BLOCK_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      MODE_MASK   = 2'd0,
      MODE_FILT4  = 2'd1,
      MODE_FILT8  = 2'd2,
      MODE_FILT16 = 2'd3
   } mode_type;

   // filter actually applied once the fallbacks are resolved
   typedef enum logic [1:0] {
      PATH_MASK,
      PATH_NARROW,
      PATH_SMOOTH8,
      PATH_SMOOTH16
   } path_type;

   // first stage -> second stage
   typedef struct packed {
      path_type                 path;
      logic [15:0][7:0]         pix;       // pix[i]: p7 at 0 .. p0 at 7, q0 at 8 .. q7 at 15
      logic signed [7:0]        f;         // masked four-tap base correction
      logic                     hev;
      logic                     edge_bad;
      logic [7:0]               ad_p0q0;
      logic [7:0]               ad_p1q1;
      logic [14:1][SUM16_W-1:0] sa;        // sixteen-tap lower half windows
      logic [14:1][SUM16_W-1:0] sb;        // sixteen-tap upper half windows
      logic [6:1][SUM8_W-1:0]   sc;        // eight-tap lower half windows
      logic [6:1][SUM8_W-1:0]   sd;        // eight-tap upper half windows
   } s1_type;

   // second stage -> output stage
   typedef struct packed {
      path_type         path;
      logic [15:0][7:0] pix;
      logic [3:0][7:0]  nar;               // new p1, p0, q0, q1
      logic [14:1][7:0] s16;
      logic [6:1][7:0]  s8;
      logic             mask_ok;
   } s2_type;

   // saturate to the signed 8-bit range
   function automatic logic signed [7:0] clamp_s8(input logic signed [10:0] v);
      if (v < -128) begin
         return $signed(8'h80);
      end else if (v > 127) begin
         return $signed(8'h7F);
      end else begin
         return $signed(v[7:0]);
      end
   endfunction

   // pixel to signed offset form
   function automatic logic signed [7:0] to_s8(input logic [7:0] v);
      return $signed(v ^ 8'h80);
   endfunction

endpackage

@@ sv/dbf_front.sv @@
// ----------------------------------------------------------------------------
// dbf_front
// First stage: unpack the line, pick the filter, mask differences,
// four-tap base correction and smoothing half-window sums.
// ----------------------------------------------------------------------------
module dbf_front (
   input  logic              clock,
   input  logic              load,
   input  logic [7:0]        edge_limit,
   input  dbf_pkg::mode_type mode,
   input  logic [63:0]       p_pixels,
   input  logic [63:0]       q_pixels,
   input  logic              mask_in,
   input  logic              hev,
   input  logic              flat,
   input  logic              flat_outer,
   output dbf_pkg::s1_type   st_ff
);

   dbf_pkg::s1_type   st_in;
   logic [15:0][7:0]  x;
   logic signed [7:0] ps1, ps0, qs0, qs1, fh;
   logic signed [10:0] t;

   function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // unpack the line into edge order
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         x[7 - k] = p_pixels[8*k +: 8];
         x[8 + k] = q_pixels[8*k +: 8];
      end
   end

   // resolve the filter with its fallbacks
   always_comb begin
      if (mode == dbf_pkg::MODE_MASK) begin
         st_in.path = dbf_pkg::PATH_MASK;
      end else if (mode == dbf_pkg::MODE_FILT16 && flat_outer && flat && mask_in) begin
         st_in.path = dbf_pkg::PATH_SMOOTH16;
      end else if ((mode == dbf_pkg::MODE_FILT8 || mode == dbf_pkg::MODE_FILT16)
                   && flat && mask_in) begin
         st_in.path = dbf_pkg::PATH_SMOOTH8;
      end else begin
         st_in.path = dbf_pkg::PATH_NARROW;
      end
   end

   // four-tap base correction
   always_comb begin
      ps1 = dbf_pkg::to_s8(x[6]);
      ps0 = dbf_pkg::to_s8(x[7]);
      qs0 = dbf_pkg::to_s8(x[8]);
      qs1 = dbf_pkg::to_s8(x[9]);
      fh  = hev ? dbf_pkg::clamp_s8(11'(ps1) - 11'(qs1)) : 8'sd0;
      t   = 11'(fh) + 11'sd3 * (11'(qs0) - 11'(ps0));
      st_in.f = mask_in ? dbf_pkg::clamp_s8(t) : 8'sd0;
   end

   // mask differences; the block test finishes in the next stage
   always_comb begin
      st_in.edge_bad = (absdiff(x[4], x[5]) > edge_limit)
                     | (absdiff(x[5], x[6]) > edge_limit)
                     | (absdiff(x[6], x[7]) > edge_limit)
                     | (absdiff(x[9], x[8]) > edge_limit)
                     | (absdiff(x[10], x[9]) > edge_limit)
                     | (absdiff(x[11], x[10]) > edge_limit);
      st_in.ad_p0q0 = absdiff(x[7], x[8]);
      st_in.ad_p1q1 = absdiff(x[6], x[9]);
   end

   // smoothing half windows, edge pixels repeated past the ends
   always_comb begin
      int kk;
      for (int i = 1; i <= 14; i++) begin
         st_in.sa[i] = '0;
         for (int j = i - 7; j <= i; j++) begin
            kk = (j < 0) ? 0 : j;
            st_in.sa[i] = st_in.sa[i] + dbf_pkg::SUM16_W'(x[kk[3:0]]);
         end
         st_in.sb[i] = dbf_pkg::SUM16_W'(x[i]);
         for (int j = i + 1; j <= i + 7; j++) begin
            kk = (j > 15) ? 15 : j;
            st_in.sb[i] = st_in.sb[i] + dbf_pkg::SUM16_W'(x[kk[3:0]]);
         end
      end
      for (int i = 1; i <= 6; i++) begin
         st_in.sc[i] = '0;
         for (int j = i - 3; j <= i; j++) begin
            kk = (j < 0) ? 4 : j + 4;
            st_in.sc[i] = st_in.sc[i] + dbf_pkg::SUM8_W'(x[kk[3:0]]);
         end
         st_in.sd[i] = dbf_pkg::SUM8_W'(x[i + 4]);
         for (int j = i + 1; j <= i + 3; j++) begin
            kk = (j > 7) ? 11 : j + 4;
            st_in.sd[i] = st_in.sd[i] + dbf_pkg::SUM8_W'(x[kk[3:0]]);
         end
      end
   end

   // carry pixels and flags along
   always_comb begin
      st_in.pix = x;
      st_in.hev = hev;
   end

   // hold while the next stage stalls
   always_ff @(posedge clock) begin
      if (load) begin
         st_ff <= st_in;
      end
   end

endmodule

@@ sv/dbf_core.sv @@
// ----------------------------------------------------------------------------
// dbf_core
// Second stage: finish the four-tap filter, the smoothing averages and
// the block limit test.
// ----------------------------------------------------------------------------
module dbf_core (
   input  logic            clock,
   input  logic            load,
   input  logic [7:0]      block_limit,
   input  dbf_pkg::s1_type st,
   output dbf_pkg::s2_type st_ff
);

   dbf_pkg::s2_type    st_in;
   logic signed [7:0]  ps1, ps0, qs0, qs1, f1, f2, g;
   logic signed [7:0]  p1n, p0n, q0n, q1n;
   logic [9:0]         blk;
   logic [11:0]        sum16;
   logic [10:0]        sum8;

   // four-tap filter outputs
   always_comb begin
      ps1 = dbf_pkg::to_s8(st.pix[6]);
      ps0 = dbf_pkg::to_s8(st.pix[7]);
      qs0 = dbf_pkg::to_s8(st.pix[8]);
      qs1 = dbf_pkg::to_s8(st.pix[9]);
      f1  = dbf_pkg::clamp_s8(11'(st.f) + 11'sd4) >>> 3;
      f2  = dbf_pkg::clamp_s8(11'(st.f) + 11'sd3) >>> 3;
      q0n = dbf_pkg::clamp_s8(11'(qs0) - 11'(f1));
      p0n = dbf_pkg::clamp_s8(11'(ps0) + 11'(f2));
      g   = st.hev ? 8'sd0 : ((f1 + 8'sd1) >>> 1);
      q1n = dbf_pkg::clamp_s8(11'(qs1) - 11'(g));
      p1n = dbf_pkg::clamp_s8(11'(ps1) + 11'(g));
      st_in.nar[0] = p1n ^ 8'h80;
      st_in.nar[1] = p0n ^ 8'h80;
      st_in.nar[2] = q0n ^ 8'h80;
      st_in.nar[3] = q1n ^ 8'h80;
   end

   // rounded smoothing averages
   always_comb begin
      sum16 = '0;
      sum8  = '0;
      for (int i = 1; i <= 14; i++) begin
         sum16 = 12'(st.sa[i]) + 12'(st.sb[i]) + 12'd8;
         st_in.s16[i] = sum16[11:4];
      end
      for (int i = 1; i <= 6; i++) begin
         sum8 = 11'(st.sc[i]) + 11'(st.sd[i]) + 11'd4;
         st_in.s8[i] = sum8[10:3];
      end
   end

   // block limit test
   always_comb begin
      blk = {1'b0, st.ad_p0q0, 1'b0} + 10'(st.ad_p1q1[7:1]);
      st_in.mask_ok = !st.edge_bad && (blk <= 10'(block_limit));
      st_in.path    = st.path;
      st_in.pix     = st.pix;
   end

   // hold while the next stage stalls
   always_ff @(posedge clock) begin
      if (load) begin
         st_ff <= st_in;
      end
   end

endmodule

@@ sv/dbf_merge.sv @@
// ----------------------------------------------------------------------------
// dbf_merge
// Output stage: place the chosen filter's pixels into the line and
// register the result word.
// ----------------------------------------------------------------------------
module dbf_merge (
   input  logic            clock,
   input  logic            load,
   input  dbf_pkg::s2_type st,
   output logic [63:0]     p_out_ff,
   output logic [63:0]     q_out_ff,
   output logic            mask_out_ff
);

   logic [15:0][7:0] x;
   logic [63:0]      p_out_in, q_out_in;
   logic             mask_out_in;

   // overwrite the pixels the chosen filter writes
   always_comb begin
      x           = st.pix;
      mask_out_in = 1'b0;
      case (st.path)
         dbf_pkg::PATH_MASK: begin
            mask_out_in = st.mask_ok;
         end
         dbf_pkg::PATH_NARROW: begin
            x[6] = st.nar[0];
            x[7] = st.nar[1];
            x[8] = st.nar[2];
            x[9] = st.nar[3];
         end
         dbf_pkg::PATH_SMOOTH8: begin
            for (int i = 1; i <= 6; i++) begin
               x[i + 4] = st.s8[i];
            end
         end
         dbf_pkg::PATH_SMOOTH16: begin
            for (int i = 1; i <= 14; i++) begin
               x[i] = st.s16[i];
            end
         end
         default: begin
            x = st.pix;
         end
      endcase
   end

   // pack back into byte order
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         p_out_in[8*k +: 8] = x[7 - k];
         q_out_in[8*k +: 8] = x[8 + k];
      end
   end

   // hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (load) begin
         p_out_ff    <= p_out_in;
         q_out_ff    <= q_out_in;
         mask_out_ff <= mask_out_in;
      end
   end

endmodule

@@ sv/deblock_edge_filter.sv @@
// A word accepted on req passes the front, core and merge registers to rsp.
// Throughput: one word per cycle, unless rsp stalls, through three register stages
// (front differences and half sums, filter core, output merge).
// Back pressure on rsp stalls each stage only when the stage ahead is full.
// Reset: synchronous, clears the stage valid bits and both limit registers.
// ----------------------------------------------------------------------------
// deblock_edge_filter
// Loop filter on one 16-pixel line across a block edge: mask evaluation
// and four-, eight- and sixteen-tap edge filters with fallbacks.
// ----------------------------------------------------------------------------
`include "deblock_edge_filter_defines.svh"

module deblock_edge_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // p_pixels[63:0], q_pixels[127:64], mask_in[128], hev[129], flat[130],
   // flat_outer[131], zero pad
   input  logic [dbf_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // p_out[63:0], q_out[127:64], mask_out[128], zero pad
   output logic [dbf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wen,
   input  logic [0:0]                      csr_index,
   input  logic [7:0]                      csr_wdata
);

   logic [7:0]      edge_limit_ff, block_limit_ff;
   logic [2:0]      vld_ff, vld_in;
   logic            rdy1, rdy2, rdy3;
   logic            in_acc, out_acc;
   dbf_pkg::s1_type s1;
   dbf_pkg::s2_type s2;
   logic [63:0]     p_out, q_out;
   logic            mask_out;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_limit_ff  <= '0;
         block_limit_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            dbf_pkg::CSR_EDGE_LIMIT:  edge_limit_ff  <= csr_wdata;
            dbf_pkg::CSR_BLOCK_LIMIT: block_limit_ff <= csr_wdata;
            default: begin
               edge_limit_ff <= edge_limit_ff;
            end
         endcase
      end
   end

   // a stage advances when it is empty or the stage ahead advances
   always_comb begin
      rdy3    = !vld_ff[2] || rsp_tready;
      rdy2    = !vld_ff[1] || rdy3;
      rdy1    = !vld_ff[0] || rdy2;
      in_acc  = req_tvalid && rdy1;
      out_acc = vld_ff[2] && rsp_tready;
      vld_in[0] = rdy1 ? req_tvalid : vld_ff[0];
      vld_in[1] = rdy2 ? vld_ff[0]  : vld_ff[1];
      vld_in[2] = rdy3 ? vld_ff[1]  : vld_ff[2];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   dbf_front u_front (
      .clock      (clock),
      .load       (rdy1),
      .edge_limit (edge_limit_ff),
      .mode       (dbf_pkg::mode_type'(req_tuser)),
      .p_pixels   (req_tdata[63:0]),
      .q_pixels   (req_tdata[127:64]),
      .mask_in    (req_tdata[128]),
      .hev        (req_tdata[129]),
      .flat       (req_tdata[130]),
      .flat_outer (req_tdata[131]),
      .st_ff      (s1)
   );

   dbf_core u_core (
      .clock       (clock),
      .load        (rdy2),
      .block_limit (block_limit_ff),
      .st          (s1),
      .st_ff       (s2)
   );

   dbf_merge u_merge (
      .clock       (clock),
      .load        (rdy3),
      .st          (s2),
      .p_out_ff    (p_out),
      .q_out_ff    (q_out),
      .mask_out_ff (mask_out)
   );

   // drive req_tready and the result channel
   assign req_tready = rdy1;
   assign rsp_tvalid = vld_ff[2];
   assign rsp_tdata  = {7'd0, mask_out, q_out, p_out};

   // an empty first stage always takes a word
   `DBF_ASSERT_ALWAYS(a_first_stage_open, !vld_ff[0] |-> req_tready)
   // a full, stalled pipeline refuses input
   `DBF_ASSERT(a_full_stall_blocks, (&vld_ff) && !rsp_tready |-> !req_tready)
   // words in flight change only by accepts on either side
   `DBF_ASSERT(a_word_count, !reset |=> ($countones(vld_ff) == $past($countones(vld_ff)) + $past(32'(in_acc)) - $past(32'(out_acc))))

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the deblocking edge filter. A directed table at zero
// limits covers flag extremes and every fallback path. Random lines then run
// under several limit settings. Each response word is compared with a typed-in
// result or a line predictor, field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DIR_ROWS       = 23;
   localparam int RAND_PHASES    = 6;
   localparam int RAND_PER_PHASE = 172;
   localparam int DRAIN_CYCLES   = 6;

   // one edge line as it enters the filter
   typedef struct packed {
      dbf_pkg::mode_type mode;
      logic [63:0]       p_pix;
      logic [63:0]       q_pix;
      logic              mask_in;
      logic              hev;
      logic              flat;
      logic              flat_outer;
   } line_word_type;

   // one filtered line
   typedef struct packed {
      logic [63:0] p_out;
      logic [63:0] q_out;
      logic        mask_out;
   } line_result_type;

   // directed row: input fields, then an optional typed-in result
   typedef struct packed {
      dbf_pkg::mode_type mode;
      logic [63:0]       p_pix;
      logic [63:0]       q_pix;
      logic              mask_in;
      logic              hev;
      logic              flat;
      logic              flat_outer;
      logic              typed;
      logic [63:0]       exp_p;
      logic [63:0]       exp_q;
      logic              exp_mask;
   } directed_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dbf_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]                      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dbf_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_wen = 1'b0;
   logic [0:0]                      csr_index = '0;
   logic [7:0]                      csr_wdata = '0;

   // predictor copy of the limit registers
   logic [7:0] edge_lim = 8'd0;
   logic [7:0] blk_lim  = 8'd0;

   line_result_type pending_lines[$];
   int              fault_count = 0;
   logic            steady = 1'b0;
   line_result_type got_line;
   line_result_type want_line;

   directed_row_type dir_rows [DIR_ROWS] = '{
      // mask evaluation with both limits at zero
      '{dbf_pkg::MODE_MASK, {8{8'h80}}, {8{8'h80}}, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, {8{8'h80}}, {8{8'h80}}, 1'b1},
      '{dbf_pkg::MODE_MASK, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 64'h0, 64'h0, 1'b1},
      '{dbf_pkg::MODE_MASK, {8{8'hFF}}, 64'h0, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, {8{8'hFF}}, 64'h0, 1'b0},
      '{dbf_pkg::MODE_MASK, 64'h80808080_81808080, {8{8'h80}}, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 64'h80808080_81808080, {8{8'h80}}, 1'b0},
      '{dbf_pkg::MODE_MASK, {8{8'h80}}, 64'h80808080_81808080, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, {8{8'h80}}, 64'h80808080_81808080, 1'b0},
      '{dbf_pkg::MODE_MASK, 64'h00112233_80808080, {8{8'h80}}, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 64'h00112233_80808080, {8{8'h80}}, 1'b1},
      '{dbf_pkg::MODE_MASK, {8{8'h80}}, 64'h80808080_80808081, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, {8{8'h80}}, 64'h80808080_80808081, 1'b0},
      // four-tap: mask clear leaves the line alone, then saturating cases
      '{dbf_pkg::MODE_FILT4, {8{8'hFF}}, 64'h0, 1'b0, 1'b1, 1'b0, 1'b0,
        1'b1, {8{8'hFF}}, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT4, {8{8'h80}}, {8{8'h80}}, 1'b1, 1'b0, 1'b0, 1'b0,
        1'b1, {8{8'h80}}, {8{8'h80}}, 1'b0},
      '{dbf_pkg::MODE_FILT4, {8{8'hFF}}, 64'h0, 1'b1, 1'b1, 1'b0, 1'b0,
        1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT4, 64'h0, {8{8'hFF}}, 1'b1, 1'b0, 1'b0, 1'b0,
        1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT4, 64'h0, {8{8'hFF}}, 1'b1, 1'b1, 1'b0, 1'b0,
        1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT4, 64'h01234567_89ABCDEF, 64'hFEDCBA98_76543210,
        1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 1'b0},
      // eight-tap and its fallbacks
      '{dbf_pkg::MODE_FILT8, {8{8'h55}}, {8{8'h55}}, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, {8{8'h55}}, {8{8'h55}}, 1'b0},
      '{dbf_pkg::MODE_FILT8, {8{8'hFF}}, 64'h0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT8, {8{8'hFF}}, 64'h0, 1'b1, 1'b1, 1'b0, 1'b1,
        1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT8, {8{8'hFF}}, 64'h0, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b1, {8{8'hFF}}, 64'h0, 1'b0},
      // sixteen-tap and its fallbacks
      '{dbf_pkg::MODE_FILT16, {8{8'hAA}}, {8{8'hAA}}, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, {8{8'hAA}}, {8{8'hAA}}, 1'b0},
      '{dbf_pkg::MODE_FILT16, {8{8'hFF}}, 64'h0, 1'b1, 1'b0, 1'b1, 1'b1,
        1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT16, 64'h0, {8{8'hFF}}, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT16, 64'h10305070_90B0D0F0, 64'hF0D0B090_70503010,
        1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT16, 64'h10305070_90B0D0F0, 64'hF0D0B090_70503010,
        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
      '{dbf_pkg::MODE_FILT16, 64'h10305070_90B0D0F0, 64'hF0D0B090_70503010,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 64'h10305070_90B0D0F0,
        64'hF0D0B090_70503010, 1'b0}
   };

   deblock_edge_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // saturate to the signed 8-bit range
   function automatic int sat8(input int v);
      return v < -128 ? -128 : (v > 127 ? 127 : v);
   endfunction

   // hold a pixel inside 0..255
   function automatic int pix_clip(input int v);
      return v < 0 ? 0 : (v > 255 ? 255 : v);
   endfunction

   function automatic int step_size(input int a, input int b);
      return a > b ? a - b : b - a;
   endfunction

   // filtered line for one input word under the current limits
   function automatic line_result_type filter_line(input line_word_type w);
      int              x [16];
      int              src [16];
      int              ps1, ps0, qs0, qs1, f, f1, f2;
      int              base, len, r, s, sum, k;
      logic            bad;
      line_result_type res;
      for (int i = 0; i < 8; i++) begin
         x[7 - i] = int'(w.p_pix[8*i +: 8]);
         x[8 + i] = int'(w.q_pix[8*i +: 8]);
      end
      res.mask_out = 1'b0;
      if (w.mode == dbf_pkg::MODE_MASK) begin
         // side steps against the edge limit, cross-edge sum against block
         bad = 1'b0;
         for (int i = 4; i < 7; i++) begin
            bad |= step_size(x[i], x[i + 1]) > int'(edge_lim);
            bad |= step_size(x[i + 4], x[i + 5]) > int'(edge_lim);
         end
         bad |= 2 * step_size(x[7], x[8]) + step_size(x[6], x[9]) / 2 > int'(blk_lim);
         res.mask_out = !bad;
      end else if ((w.mode == dbf_pkg::MODE_FILT16 && w.flat_outer && w.flat && w.mask_in)
                   || (w.mode != dbf_pkg::MODE_FILT4 && w.flat && w.mask_in)) begin
         // rounded averages over a clamped window
         if (w.mode == dbf_pkg::MODE_FILT16 && w.flat_outer) begin
            base = 0; len = 16; r = 7; s = 4;
         end else begin
            base = 4; len = 8; r = 3; s = 3;
         end
         src = x;
         for (int i = 1; i < len - 1; i++) begin
            sum = src[base + i];
            for (int j = i - r; j <= i + r; j++) begin
               k = j < 0 ? 0 : (j > len - 1 ? len - 1 : j);
               sum += src[base + k];
            end
            x[base + i] = ((sum + (1 << (s - 1))) >> s) & 255;
         end
      end else begin
         // four-tap correction in offset form
         ps1 = x[6] - 128;
         ps0 = x[7] - 128;
         qs0 = x[8] - 128;
         qs1 = x[9] - 128;
         f = w.hev ? sat8(ps1 - qs1) : 0;
         f = sat8(f + 3 * (qs0 - ps0));
         if (!w.mask_in) begin
            f = 0;
         end
         f1 = sat8(f + 4) >>> 3;
         f2 = sat8(f + 3) >>> 3;
         x[8] = sat8(qs0 - f1) + 128;
         x[7] = sat8(ps0 + f2) + 128;
         f = w.hev ? 0 : (f1 + 1) >>> 1;
         x[9] = sat8(qs1 - f) + 128;
         x[6] = sat8(ps1 + f) + 128;
      end
      for (int i = 0; i < 8; i++) begin
         res.p_out[8*i +: 8] = x[7 - i][7:0];
         res.q_out[8*i +: 8] = x[8 + i][7:0];
      end
      return res;
   endfunction

   // random line: mostly gentle ramps around the edge, some noise and extremes
   function automatic line_word_type random_line();
      line_word_type w;
      int            pix [16];
      int            kind, span;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 128) : $urandom_range(0, 12);
         pix[7] = $urandom_range(0, 255);
         for (int i = 6; i >= 0; i--) begin
            pix[i] = pix_clip(pix[i + 1] + int'($urandom_range(0, 2 * span)) - span);
         end
         pix[8] = pix_clip(pix[7] + int'($urandom_range(0, 4 * span)) - 2 * span);
         for (int i = 9; i < 16; i++) begin
            pix[i] = pix_clip(pix[i - 1] + int'($urandom_range(0, 2 * span)) - span);
         end
         for (int i = 0; i < 8; i++) begin
            w.p_pix[8*i +: 8] = pix[7 - i][7:0];
            w.q_pix[8*i +: 8] = pix[8 + i][7:0];
         end
      end else if (kind < 80) begin
         w.p_pix = {$urandom, $urandom};
         w.q_pix = {$urandom, $urandom};
      end else begin
         for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 3))
               0: w.p_pix[8*i +: 8] = 8'h00;
               1: w.p_pix[8*i +: 8] = 8'hFF;
               2: w.p_pix[8*i +: 8] = 8'h80;
               default: w.p_pix[8*i +: 8] = 8'h7F;
            endcase
            w.q_pix[8*i +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         end
      end
      w.mode       = dbf_pkg::mode_type'(2'($urandom_range(0, 3)));
      w.mask_in    = $urandom_range(0, 99) < 80;
      w.hev        = 1'($urandom_range(0, 1));
      w.flat       = $urandom_range(0, 99) < 70;
      w.flat_outer = $urandom_range(0, 99) < 70;
      return w;
   endfunction

   // present one word, record its expected result, wait for acceptance
   task automatic send_line(input line_word_type w, input logic typed,
                            input line_result_type typed_res);
      line_result_type want;
      want = typed ? typed_res : filter_line(w);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, w.flat_outer, w.flat, w.hev, w.mask_in, w.q_pix, w.p_pix};
      req_tuser  <= w.mode;
      do @(negedge clock); while (!req_tready);
      pending_lines.push_back(want);
      @(posedge clock);
   endtask

   // drain the pipe, then load both limits
   task automatic write_limits(input logic [7:0] edge_v, input logic [7:0] block_v);
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= dbf_pkg::CSR_EDGE_LIMIT;
      csr_wdata <= edge_v;
      @(posedge clock);
      csr_index <= dbf_pkg::CSR_BLOCK_LIMIT;
      csr_wdata <= block_v;
      @(posedge clock);
      csr_wen  <= 1'b0;
      edge_lim = edge_v;
      blk_lim  = block_v;
   endtask

   // response side: random stalls outside the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
   end

   // compare each accepted response word with the oldest expectation
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_line.p_out    = rsp_tdata[63:0];
         got_line.q_out    = rsp_tdata[127:64];
         got_line.mask_out = rsp_tdata[128];
         if (pending_lines.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected rsp word %h", $time, rsp_tdata);
         end else begin
            want_line = pending_lines.pop_front();
            if (got_line.p_out !== want_line.p_out) begin
               fault_count++;
               $display("%0t: p_out expected %h actual %h",
                        $time, want_line.p_out, got_line.p_out);
            end
            if (got_line.q_out !== want_line.q_out) begin
               fault_count++;
               $display("%0t: q_out expected %h actual %h",
                        $time, want_line.q_out, got_line.q_out);
            end
            if (got_line.mask_out !== want_line.mask_out) begin
               fault_count++;
               $display("%0t: mask_out expected %b actual %b",
                        $time, want_line.mask_out, got_line.mask_out);
            end
         end
      end
   end

   // stimulus: directed table at reset limits, then random phases
   initial begin
      line_word_type   w;
      line_result_type typed_res;
      logic [7:0]      edge_v, block_v;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < DIR_ROWS; n++) begin
         w.mode       = dir_rows[n].mode;
         w.p_pix      = dir_rows[n].p_pix;
         w.q_pix      = dir_rows[n].q_pix;
         w.mask_in    = dir_rows[n].mask_in;
         w.hev        = dir_rows[n].hev;
         w.flat       = dir_rows[n].flat;
         w.flat_outer = dir_rows[n].flat_outer;
         typed_res    = '{dir_rows[n].exp_p, dir_rows[n].exp_q, dir_rows[n].exp_mask};
         send_line(w, dir_rows[n].typed, typed_res);
      end
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin edge_v = 8'd255; block_v = 8'd255; end
            1: begin edge_v = 8'd0;   block_v = 8'd255; end
            2: begin edge_v = 8'd255; block_v = 8'd0;   end
            3: begin
               edge_v  = 8'($urandom_range(0, 15));
               block_v = 8'($urandom_range(0, 60));
            end
            4: begin
               edge_v  = 8'($urandom_range(0, 15));
               block_v = 8'($urandom_range(0, 255));
            end
            default: begin
               edge_v  = 8'($urandom_range(0, 255));
               block_v = 8'($urandom_range(0, 255));
            end
         endcase
         write_limits(edge_v, block_v);
         // one phase runs with no idling on either side
         steady = (ph == 2);
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            send_line(random_line(), 1'b0, '0);
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_lines.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/dbf_pkg.sv
sv/dbf_front.sv
sv/dbf_core.sv
sv/dbf_merge.sv
sv/deblock_edge_filter.sv
bench/testbench.sv
